FILE: rtl/direct_mapped_transposition_table_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef DIRECT_MAPPED_TRANSPOSITION_TABLE_UNIT_MACROS_SVH
`define DIRECT_MAPPED_TRANSPOSITION_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define DMTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmtt check failed");

// Next-cycle implication, switched off while reset is asserted.
`define DMTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmtt check failed");

// Next-cycle implication that stays active through reset.
`define DMTT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dmtt check failed");

`endif

FILE: rtl/dmtt_pkg.sv
`timescale 1ns / 1ps

package dmtt_pkg;

    localparam int INDEX_BITS_DEF   = 16;
    localparam int SAMPLE_LIMIT_DEF = 1000;
    localparam int PER_MILLE        = 1000;

    localparam int ACTION_W   = 3;
    localparam int KEY_W      = 64;
    localparam int MOVE_W     = 16;
    localparam int SCORE_W    = 16;
    localparam int DEPTH_W    = 8;
    localparam int BOUND_W    = 2;
    localparam int GEN_W      = 8;
    localparam int PERMILLE_W = 10;

    localparam logic [ACTION_W-1:0] ACT_STORE      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PROBE      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_NEW_SEARCH = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FILL       = 3'd4;

    // One table slot: full key and the packed payload.
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [GEN_W-1:0]          gen;
        logic [BOUND_W-1:0]        bound;
        logic signed [DEPTH_W-1:0] depth;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: rtl/dmtt_mem.sv
`timescale 1ns / 1ps

module dmtt_mem #(
    parameter int INDEX_BITS = 16,
    parameter int DATA_W     = 114
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [INDEX_BITS-1:0] i_waddr,
    input  logic [DATA_W-1:0]     i_wdata,
    input  logic                  i_re,
    input  logic [INDEX_BITS-1:0] i_raddr,
    output logic [DATA_W-1:0]     o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1 << INDEX_BITS)-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dmtt_div.sv
`timescale 1ns / 1ps

module dmtt_div #(
    parameter int DIVISOR = 1000,
    parameter int DW      = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [DW-1:0]                       i_dividend,
    output logic                                o_done,
    output logic [dmtt_pkg::PERMILLE_W-1:0]     o_quot
);

    import dmtt_pkg::*;

    // Division by a constant as a multiply by its rounded-up reciprocal. With the shift set to
    // DW plus the ceiling of log2 of the divisor, the quotient is exact for every DW-bit dividend.
    localparam int              LW      = $clog2(DIVISOR);
    localparam int              SH      = DW + LW;
    localparam int              MW      = DW + 2;
    localparam int              PW      = DW + MW;
    localparam longint unsigned RECIP   =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0]   RECIP_M = MW'(RECIP);

    logic [PW-1:0] r_prod;
    logic          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PW'(i_dividend) * PW'(RECIP_M);
        end
    end

    assign o_done = r_done;
    assign o_quot = PERMILLE_W'(r_prod >> SH);

endmodule

FILE: rtl/direct_mapped_transposition_table_unit.sv
`timescale 1ns / 1ps

// Channel  | Handshake               | Payload
// ---------+-------------------------+--------------------------------------------
// command  | start, busy             | i_action, i_key, i_move, i_score, i_depth,
//          |                         | i_bound
// result   | o_done (one-cycle pulse)| o_hit, o_found_*, o_permille
//
// Store and probe answer after a read of the slot memory, then compare and write back. New
// search and unused codes answer in the cycle after the item is taken.
// Clear writes one slot a cycle and answers with the write of the last slot.
// Fill query reads min(2^INDEX_BITS, SAMPLE_LIMIT) slots, one a cycle, then divides by a
// reciprocal multiply; it answers once the quotient is ready.
// After reset the clearing pass writes every slot; busy is high whenever not idle.

module direct_mapped_transposition_table_unit #(
    parameter int INDEX_BITS   = dmtt_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_LIMIT = dmtt_pkg::SAMPLE_LIMIT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [dmtt_pkg::ACTION_W-1:0]          i_action,
    input  logic [dmtt_pkg::KEY_W-1:0]             i_key,
    input  logic [dmtt_pkg::MOVE_W-1:0]            i_move,
    input  logic signed [dmtt_pkg::SCORE_W-1:0]    i_score,
    input  logic signed [dmtt_pkg::DEPTH_W-1:0]    i_depth,
    input  logic [dmtt_pkg::BOUND_W-1:0]           i_bound,
    output logic                                   o_done,
    output logic                                   o_hit,
    output logic [dmtt_pkg::MOVE_W-1:0]            o_found_move,
    output logic signed [dmtt_pkg::SCORE_W-1:0]    o_found_score,
    output logic signed [dmtt_pkg::DEPTH_W-1:0]    o_found_depth,
    output logic [dmtt_pkg::BOUND_W-1:0]           o_found_bound,
    output logic [dmtt_pkg::GEN_W-1:0]             o_found_age,
    output logic [dmtt_pkg::PERMILLE_W-1:0]        o_permille
);

    import dmtt_pkg::*;

    localparam int SLOTS  = 1 << INDEX_BITS;
    localparam int SAMPLE = (SLOTS < SAMPLE_LIMIT) ? SLOTS : SAMPLE_LIMIT;
    localparam int CW     = $clog2(SAMPLE + 1);
    localparam int DW     = $clog2(SAMPLE * PER_MILLE + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_FILL,
        S_FILL_TAIL,
        S_DIV
    } t_state;

    t_state                 r_state;
    logic [INDEX_BITS-1:0]  r_idx;
    logic [GEN_W-1:0]       r_gen;
    logic                   r_clr_reply;
    logic [CW-1:0]          r_filled;
    logic                   r_rd_vld;
    logic                   r_div_go;

    logic                   r_done;
    logic                   r_hit;
    logic [MOVE_W-1:0]      r_found_move;
    logic [SCORE_W-1:0]     r_found_score;
    logic [DEPTH_W-1:0]     r_found_depth;
    logic [BOUND_W-1:0]     r_found_bound;
    logic [GEN_W-1:0]       r_found_age;
    logic [PERMILLE_W-1:0]  r_permille;

    logic [ACTION_W-1:0]    r_act;
    logic [KEY_W-1:0]       r_key;
    logic [MOVE_W-1:0]      r_move;
    logic [SCORE_W-1:0]     r_score;
    logic [DEPTH_W-1:0]     r_depth;
    logic [BOUND_W-1:0]     r_bound;

    logic                   mem_we;
    logic [INDEX_BITS-1:0]  mem_waddr;
    t_entry                 mem_wdata;
    logic                   mem_re;
    logic [INDEX_BITS-1:0]  mem_raddr;
    logic [ENTRY_W-1:0]     mem_rdata;
    t_entry                 rd;
    t_entry                 new_entry;

    logic                   keep_old;
    logic                   live;
    logic                   div_done;
    logic [PERMILLE_W-1:0]  div_quot;
    logic [DW-1:0]          dividend;

    assign rd = t_entry'(mem_rdata);

    // A live slot holds a key and was written in the current generation.
    assign live = (rd.key != '0) && (rd.gen == r_gen);

    // Depth-preferred replacement: a live, deeper entry survives the store.
    assign keep_old = live && (rd.depth > $signed(r_depth));

    always_comb begin
        new_entry.key   = r_key;
        new_entry.gen   = r_gen;
        new_entry.bound = r_bound;
        new_entry.depth = r_depth;
        new_entry.score = r_score;
        new_entry.move  = r_move;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                mem_re    = start;
                mem_raddr = i_key[INDEX_BITS-1:0];
            end
            S_LOOK: begin
                mem_we    = (r_act == ACT_STORE) && !keep_old;
                mem_waddr = r_key[INDEX_BITS-1:0];
                mem_wdata = new_entry;
            end
            S_FILL: begin
                mem_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    dmtt_mem #(
        .INDEX_BITS (INDEX_BITS),
        .DATA_W     (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign dividend = DW'(r_filled) * DW'(PER_MILLE);

    dmtt_div #(
        .DIVISOR (SAMPLE),
        .DW      (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (dividend),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_act   <= i_action;
            r_key   <= i_key;
            r_move  <= i_move;
            r_score <= i_score;
            r_depth <= i_depth;
            r_bound <= i_bound;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_idx         <= '0;
            r_gen         <= '0;
            r_clr_reply   <= 1'b0;
            r_filled      <= '0;
            r_rd_vld      <= 1'b0;
            r_div_go      <= 1'b0;
            r_done        <= 1'b0;
            r_hit         <= 1'b0;
            r_found_move  <= '0;
            r_found_score <= '0;
            r_found_depth <= '0;
            r_found_bound <= '0;
            r_found_age   <= '0;
            r_permille    <= '0;
        end else begin
            // Result fields read zero unless the current item sets them.
            r_done        <= 1'b0;
            r_hit         <= 1'b0;
            r_found_move  <= '0;
            r_found_score <= '0;
            r_found_depth <= '0;
            r_found_bound <= '0;
            r_found_age   <= '0;
            r_permille    <= '0;
            r_rd_vld      <= 1'b0;
            r_div_go      <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + INDEX_BITS'(1);
                    if (r_idx == {INDEX_BITS{1'b1}}) begin
                        r_state     <= S_IDLE;
                        r_done      <= r_clr_reply;
                        r_clr_reply <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        case (i_action)
                            ACT_STORE, ACT_PROBE: begin
                                r_state <= S_LOOK;
                            end
                            ACT_CLEAR: begin
                                r_state     <= S_CLEAR;
                                r_idx       <= '0;
                                r_gen       <= '0;
                                r_clr_reply <= 1'b1;
                            end
                            ACT_NEW_SEARCH: begin
                                r_gen  <= r_gen + GEN_W'(1);
                                r_done <= 1'b1;
                            end
                            ACT_FILL: begin
                                r_state  <= S_FILL;
                                r_idx    <= '0;
                                r_filled <= '0;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_LOOK: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    if (r_act == ACT_PROBE && rd.key == r_key) begin
                        r_hit         <= 1'b1;
                        r_found_move  <= rd.move;
                        r_found_score <= rd.score;
                        r_found_depth <= rd.depth;
                        r_found_bound <= rd.bound;
                        r_found_age   <= rd.gen;
                    end
                end
                S_FILL: begin
                    r_rd_vld <= 1'b1;
                    r_idx    <= r_idx + INDEX_BITS'(1);
                    if (r_rd_vld && live) begin
                        r_filled <= r_filled + CW'(1);
                    end
                    if (r_idx == INDEX_BITS'(SAMPLE - 1)) begin
                        r_state <= S_FILL_TAIL;
                    end
                end
                S_FILL_TAIL: begin
                    if (r_rd_vld && live) begin
                        r_filled <= r_filled + CW'(1);
                    end
                    r_state  <= S_DIV;
                    r_div_go <= 1'b1;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state    <= S_IDLE;
                        r_done     <= 1'b1;
                        r_permille <= div_quot;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_found_move  = r_found_move;
    assign o_found_score = r_found_score;
    assign o_found_depth = r_found_depth;
    assign o_found_bound = r_found_bound;
    assign o_found_age   = r_found_age;
    assign o_permille    = r_permille;

endmodule

FILE: rtl/dmtt_checker.sv
`timescale 1ns / 1ps
`include "direct_mapped_transposition_table_unit_macros.svh"

module dmtt_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic [dmtt_pkg::ACTION_W-1:0]          i_action,
    input logic                                   o_done,
    input logic                                   o_hit,
    input logic [dmtt_pkg::PERMILLE_W-1:0]        o_permille
);

    import dmtt_pkg::*;

    logic acc_lookup;

    assign acc_lookup = start && !busy && (i_action == ACT_STORE || i_action == ACT_PROBE);

    // Reset always leads into the clearing pass.
    `DMTT_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, busy)

    // A hit or a fill figure only appears on a result item.
    `DMTT_ASSERT_IMPL(a_hit_marked, i_clk, i_rst_n, o_hit || o_permille != '0, o_done)

    // The fill figure never exceeds one thousand.
    `DMTT_ASSERT_IMPL(a_permille_range, i_clk, i_rst_n, o_done, o_permille <= 10'd1000)

    // A store or probe answers once its slot has been read and compared.
    `DMTT_ASSERT_NEXT(a_lookup_latency, i_clk, i_rst_n, acc_lookup ##1 i_rst_n, o_done)

endmodule

bind direct_mapped_transposition_table_unit dmtt_checker u_dmtt_checker (.*);
